// ===== src/tdch_pkg.sv =====
// Package: shared types and constants for the distance calibrate-and-hold block.
package tdch_pkg;

    // Configuration register indexes
    localparam logic [2:0] CfgRadius          = 3'd0;
    localparam logic [2:0] CfgTrackLength     = 3'd1;
    localparam logic [2:0] CfgStableNeeded    = 3'd2;
    localparam logic [2:0] CfgFailLimit       = 3'd3;
    localparam logic [2:0] CfgSamplePeriodMax = 3'd4;

    // Register reset values
    localparam logic [7:0] RadiusReset          = 8'd20;
    localparam logic [9:0] TrackLengthReset     = 10'd450;
    localparam logic [5:0] StableNeededReset    = 6'd50;
    localparam logic [4:0] FailLimitReset       = 5'd20;
    localparam logic [2:0] SamplePeriodMaxReset = 3'd5;

    // Calibration band (exclusive top) and stability window
    localparam logic [15:0] CalBandTop  = 16'd100;
    localparam logic [16:0] NearWindow  = 17'd2;
    localparam logic [5:0]  StableMax   = 6'd63;

    typedef struct packed {
        logic        reading_ready;
        logic [15:0] raw_distance;
    } t_in_item;

    typedef struct packed {
        logic [9:0] position;
        logic       position_valid;
        logic       calibrated;
        logic [7:0] offset_value;
    } t_out_item;

    typedef struct packed {
        logic [2:0] index;
        logic [9:0] wdata;
    } t_cfg_wr;

    // Current register contents, passed from the register file to the datapath
    typedef struct packed {
        logic [7:0] radius;
        logic [9:0] track_length;
        logic [5:0] stable_needed;
        logic [4:0] fail_limit;
        logic [2:0] sample_period_max;
    } t_cfg;

endpackage

// ===== src/tdch_stream_if.sv =====
// Interface: valid/ready channel carrying one payload of a chosen type.
interface tdch_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/tdch_cfg_regs.sv =====
// Configuration register file with reset defaults.
module tdch_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [2:0]         i_index,
    input  logic [9:0]         i_wdata,
    output tdch_pkg::t_cfg     o_cfg
);

    tdch_pkg::t_cfg r_cfg;
    tdch_pkg::t_cfg n_cfg;

    // Decode the write into the addressed register; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_index)
                tdch_pkg::CfgRadius:          n_cfg.radius            = i_wdata[7:0];
                tdch_pkg::CfgTrackLength:     n_cfg.track_length      = i_wdata;
                tdch_pkg::CfgStableNeeded:    n_cfg.stable_needed     = i_wdata[5:0];
                tdch_pkg::CfgFailLimit:       n_cfg.fail_limit        = i_wdata[4:0];
                tdch_pkg::CfgSamplePeriodMax: n_cfg.sample_period_max = i_wdata[2:0];
                default:                      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius            <= tdch_pkg::RadiusReset;
            r_cfg.track_length      <= tdch_pkg::TrackLengthReset;
            r_cfg.stable_needed     <= tdch_pkg::StableNeededReset;
            r_cfg.fail_limit        <= tdch_pkg::FailLimitReset;
            r_cfg.sample_period_max <= tdch_pkg::SamplePeriodMaxReset;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/tof_distance_calibrate_and_hold.sv =====
// Top level: offset calibration, decimated sampling and held position output.
//
//  Channel   Direction  Payload                                        Transfer when
//  i_in      sink       reading_ready, raw_distance                    valid && ready
//  o_out     source     position, position_valid, calibrated, offset   valid && ready
//  i_cfg     sink       index, wdata                                   valid && ready
//
// One item per cycle unless output stalls; state and result registers load together.
// Result is valid in the cycle after the input transfer, held in the output register.
// i_in.ready is high whenever the output register is empty or being drained this cycle.
// i_cfg.ready is always high; writes land at the edge of the transfer.
// Synchronous active-low reset restores register defaults and clears all state but r_out.
module tof_distance_calibrate_and_hold (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tdch_stream_if.sink   i_in,
    tdch_stream_if.source o_out,
    tdch_stream_if.sink   i_cfg
);

    tdch_pkg::t_cfg      w_cfg;
    tdch_pkg::t_in_item  w_in;
    tdch_pkg::t_cfg_wr   w_cfg_wr;

    // Block state
    logic        r_cal_done,  n_cal_done;
    logic [5:0]  r_stable,    n_stable;
    logic [15:0] r_prev,      n_prev;
    logic [7:0]  r_offset,    n_offset;
    logic [9:0]  r_held,      n_held;
    logic [4:0]  r_miss,      n_miss;
    logic [2:0]  r_dec,       n_dec;

    // Output register
    logic                r_out_valid;
    tdch_pkg::t_out_item r_out;
    logic                w_valid_bit;

    logic        w_in_xfer;
    logic        w_in_band;
    logic        w_near;
    logic [5:0]  w_need;
    logic [15:0] w_diff;
    logic [17:0] w_span;
    logic        w_advance;

    assign w_in     = i_in.data;
    assign w_cfg_wr = i_cfg.data;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    tdch_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg.valid),
        .i_index (w_cfg_wr.index),
        .i_wdata (w_cfg_wr.wdata),
        .o_cfg   (w_cfg)
    );

    // Handshake: accept while the result slot is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_in_xfer  = i_in.valid && i_in.ready;

    // Calibration checks
    assign w_in_band = (w_in.raw_distance != 16'd0) && (w_in.raw_distance < tdch_pkg::CalBandTop);
    assign w_near    = (({1'b0, w_in.raw_distance} + tdch_pkg::NearWindow) >= {1'b0, r_prev})
                    && ({1'b0, w_in.raw_distance} <= ({1'b0, r_prev} + tdch_pkg::NearWindow));
    assign w_need    = (w_cfg.stable_needed == 6'd0) ? 6'd1 : w_cfg.stable_needed;

    // Correction: accept when raw >= offset and (raw - offset) + 2*radius fits in the track
    assign w_diff = w_in.raw_distance - {8'd0, r_offset};
    assign w_span = {2'd0, w_diff} + {9'd0, w_cfg.radius, 1'b0};

    // Next state for one item
    always_comb begin
        n_cal_done  = r_cal_done;
        n_stable    = r_stable;
        n_prev      = r_prev;
        n_offset    = r_offset;
        n_held      = r_held;
        n_miss      = r_miss;
        n_dec       = r_dec;
        w_valid_bit = 1'b1;
        w_advance   = r_cal_done;

        if (!r_cal_done) begin
            if (w_in.reading_ready) begin
                if (w_in_band && w_near) begin
                    n_stable = (r_stable == tdch_pkg::StableMax) ? r_stable : r_stable + 6'd1;
                end else begin
                    n_stable = 6'd0;
                end
                n_prev = w_in.raw_distance;
                if (n_stable >= w_need) begin
                    n_cal_done = 1'b1;
                    n_offset   = w_in.raw_distance[7:0];
                    n_held     = {2'd0, w_cfg.radius};
                end
            end
        end else if (r_dec == 3'd0) begin
            if (!w_in.reading_ready) begin
                // missed sample: count, or flag past the limit; stay on a sample tick
                if (r_miss < w_cfg.fail_limit) begin
                    n_miss = r_miss + 5'd1;
                end else begin
                    w_valid_bit = 1'b0;
                end
                w_advance = 1'b0;
            end else begin
                n_miss = 5'd0;
                if ((w_in.raw_distance >= {8'd0, r_offset})
                        && (w_span <= {8'd0, w_cfg.track_length})) begin
                    n_held = w_diff[9:0] + {2'd0, w_cfg.radius};
                end
            end
        end

        // Decimation counter wraps after its top value
        if (w_advance) begin
            n_dec = (r_dec < w_cfg.sample_period_max) ? r_dec + 3'd1 : 3'd0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_done <= 1'b0;
            r_stable   <= 6'd0;
            r_prev     <= 16'd0;
            r_offset   <= 8'd0;
            r_held     <= 10'd0;
            r_miss     <= 5'd0;
            r_dec      <= 3'd0;
        end else if (w_in_xfer) begin
            r_cal_done <= n_cal_done;
            r_stable   <= n_stable;
            r_prev     <= n_prev;
            r_offset   <= n_offset;
            r_held     <= n_held;
            r_miss     <= n_miss;
            r_dec      <= n_dec;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_out.position       <= n_held;
            r_out.position_valid <= w_valid_bit;
            r_out.calibrated     <= n_cal_done;
            r_out.offset_value   <= n_offset;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    // Calibration, once reached, is never lost
    a_cal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal_done |=> r_cal_done)
        else $error("calibration flag dropped");

    // Decimation counter idles at zero until calibrated
    a_dec_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cal_done |-> (r_dec == 3'd0))
        else $error("decimation counter moved during calibration");

    // An invalid result only ever comes from a calibrated block
    a_invalid_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.position_valid) |-> (r_out.calibrated && r_cal_done))
        else $error("invalid result while calibrating");

    // Every input transfer leaves a result waiting
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_out_valid)
        else $error("result register not loaded");

    // Offset stays put until calibration completes
    a_offset_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_cal_done && !n_cal_done) |-> (n_offset == r_offset))
        else $error("offset changed before calibration finished");
`endif

endmodule
